FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check with reset masking; prop may use |-> or |=>.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: hdl/ccp_pkg.sv
package ccp_pkg;

	typedef logic signed [31:0] coord_t;
	typedef logic [30:0]        scale_t;
	typedef logic [30:0]        q30_t;

	localparam q30_t Q30_ONE = 31'h4000_0000;

	// divider: one quotient bit per cycle
	localparam int DIV_STEPS   = 31;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	// multiplier: 8-bit digits of the second operand, LSB first
	localparam int MUL_DIGIT_W = 8;
	localparam int MUL_OPB_W   = 32;
	localparam int MUL_DIGITS  = MUL_OPB_W / MUL_DIGIT_W;
	localparam int MUL_CNT_W   = $clog2(MUL_DIGITS);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ABS,
		ST_CLASS,
		ST_DIV,
		ST_EVAL,
		ST_MUL1,
		ST_MUL2,
		ST_POLY,
		ST_MUL3,
		ST_EMIT
	} ccp_state_t;

endpackage

FILE: hdl/ccp_ifs.sv
interface ccp_in_if;
	import ccp_pkg::*;

	logic   valid;
	logic   ready;
	coord_t x_coord;
	coord_t y_coord;
	scale_t length_scale;
	logic   last_dim;

	modport source (output valid, output x_coord, output y_coord, output length_scale,
		output last_dim, input ready);
	modport sink (input valid, input x_coord, input y_coord, input length_scale,
		input last_dim, output ready);
endinterface

interface ccp_out_if;
	import ccp_pkg::*;

	logic valid;
	logic ready;
	q30_t correlation;

	modport source (output valid, output correlation, input ready);
	modport sink (input valid, input correlation, output ready);
endinterface

FILE: hdl/cubic_correlation_product.sv
// channel  | modport | beat contents
// item     | sink    | x_coord, y_coord, length_scale, last_dim
// result   | source  | correlation (Q1.30), one beat per item with last_dim set
//
// One item at a time, with the time for a non-zero factor set mainly by the bit-serial
// divider (31 quotient bits) and three passes of the 4-digit multiplier; a factor
// that is zero skips the divider.
// The last item of a pair passes through ST_EMIT to load the output register.
// Reset restores the running product to 1.0 and empties the output register.
// A stalled result holds only the last item of the next pair; earlier ones proceed.
`include "assert_macros.svh"

module cubic_correlation_product (
	input  logic       clk,
	input  logic       arst_n,
	ccp_in_if.sink     item,
	ccp_out_if.source  result
);
	import ccp_pkg::*;

	ccp_state_t         state_q, state_d;
	logic signed [32:0] diff_q;
	logic [32:0]        a_q;
	scale_t             scale_q;
	logic               last_q;
	logic               first_q;
	q30_t               op_q;
	q30_t               m1_q;
	q30_t               r_q;
	q30_t               prod_q;
	q30_t               out_q;
	logic               out_valid_q;

	logic               zero_c;
	logic               first_c;
	logic               div_start, div_done;
	q30_t               div_q;
	logic               mul_start, mul_done;
	q30_t               mul_a, mul_b, mul_p;
	logic               emit_load;
	logic               accept;
	q30_t               t_c;
	logic [32:0]        six_c;
	q30_t               r_c;
	logic               in_mul_c;

	assign accept  = item.valid && item.ready;
	assign zero_c  = (scale_q == '0) || (a_q > {2'b0, scale_q});
	assign first_c = {a_q, 1'b0} <= {3'b0, scale_q};

	// first branch: 1 - 6(d^2 - d^3); second: 2 e^3
	assign t_c   = m1_q - mul_p;
	assign six_c = {t_c, 2'b0} + {1'b0, t_c, 1'b0};
	assign r_c   = first_q ? (Q30_ONE - six_c[30:0]) : {mul_p[29:0], 1'b0};

	assign in_mul_c = (state_q == ST_MUL1) || (state_q == ST_MUL2) || (state_q == ST_MUL3);

	ccp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (a_q[30:0]),
		.divisor  (scale_q),
		.done     (div_done),
		.quot     (div_q)
	);

	ccp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.done   (mul_done),
		.prod   (mul_p)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (item.valid) state_d = ST_ABS;
			ST_ABS:   state_d = ST_CLASS;
			ST_CLASS: state_d = zero_c ? ST_MUL3 : ST_DIV;
			ST_DIV:   if (div_done) state_d = ST_EVAL;
			ST_EVAL:  state_d = ST_MUL1;
			ST_MUL1:  if (mul_done) state_d = ST_MUL2;
			ST_MUL2:  if (mul_done) state_d = ST_POLY;
			ST_POLY:  state_d = ST_MUL3;
			ST_MUL3:  if (mul_done) state_d = last_q ? ST_EMIT : ST_IDLE;
			ST_EMIT:  if (!out_valid_q || result.ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item.ready = 1'b0;
		div_start  = 1'b0;
		mul_start  = 1'b0;
		mul_a      = op_q;
		mul_b      = op_q;
		emit_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: item.ready = 1'b1;
			ST_DIV:  div_start = 1'b1;
			ST_MUL1: mul_start = 1'b1;
			ST_MUL2: begin
				mul_start = 1'b1;
				mul_a     = m1_q;
			end
			ST_MUL3: begin
				mul_start = 1'b1;
				mul_a     = prod_q;
				mul_b     = r_q;
			end
			ST_EMIT: emit_load = !out_valid_q || result.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prod_q      <= Q30_ONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MUL3 && mul_done) begin
				prod_q <= mul_p;
			end else if (emit_load) begin
				prod_q <= Q30_ONE;
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			diff_q  <= 33'(item.x_coord) - 33'(item.y_coord);
			scale_q <= item.length_scale;
			last_q  <= item.last_dim;
		end
		if (state_q == ST_ABS) begin
			a_q <= diff_q[32] ? 33'(-diff_q) : 33'(diff_q);
		end
		if (state_q == ST_CLASS) begin
			first_q <= first_c;
			r_q     <= '0;
		end
		if (state_q == ST_EVAL) begin
			op_q <= first_q ? div_q : (Q30_ONE - div_q);
		end
		if (state_q == ST_MUL1 && mul_done) begin
			m1_q <= mul_p;
		end
		if (state_q == ST_POLY) begin
			r_q <= r_c;
		end
		if (emit_load) begin
			out_q <= prod_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.correlation = out_q;

	`ASSERT_NEVER(a_prod_range, prod_q > Q30_ONE, "running product above 1.0")
	`ASSERT_CLK(a_div_quot, div_done |-> div_q <= Q30_ONE, "quotient above 1.0")
	`ASSERT_CLK(a_div_state, div_done |-> state_q == ST_DIV, "divider finished out of turn")
	`ASSERT_CLK(a_mul_state, mul_done |-> in_mul_c, "multiplier finished out of turn")
	`ASSERT_CLK(a_emit_src, $rose(result.valid) |-> $past(state_q) == ST_EMIT, "result raised outside emit")

endmodule

FILE: hdl/ccp_div.sv
module ccp_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  ccp_pkg::q30_t   dividend,
	input  ccp_pkg::scale_t divisor,
	output logic            done,
	output ccp_pkg::q30_t   quot
);
	import ccp_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [31:0]          rem_q;
	q30_t                 quo_q;
	logic                 ge;
	logic [31:0]          rem_sub;
	logic                 launch;

	assign launch  = start && !busy_q && !done_q;
	assign ge      = rem_q >= {1'b0, divisor};
	assign rem_sub = ge ? (rem_q - {1'b0, divisor}) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (launch) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// restoring division: the remainder stays below the divisor, so doubling fits 32 bits
	always_ff @(posedge clk) begin
		if (launch) begin
			rem_q <= {1'b0, dividend};
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= {rem_sub[30:0], 1'b0};
			quo_q <= {quo_q[29:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

FILE: hdl/ccp_mul.sv
module ccp_mul (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  ccp_pkg::q30_t op_a,
	input  ccp_pkg::q30_t op_b,
	output logic          done,
	output ccp_pkg::q30_t prod
);
	import ccp_pkg::*;

	logic                   busy_q;
	logic                   done_q;
	logic [MUL_CNT_W-1:0]   cnt_q;
	q30_t                   a_q;
	logic [MUL_OPB_W-1:0]   b_q;
	logic [31:0]            hi_q;
	logic [31:0]            lo_q;
	logic [38:0]            pp;
	logic [39:0]            sum;
	logic                   launch;

	assign launch = start && !busy_q && !done_q;
	assign pp     = {8'b0, a_q} * {31'b0, b_q[MUL_DIGIT_W-1:0]};
	assign sum    = {8'b0, hi_q} + {1'b0, pp};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (launch) begin
				busy_q <= 1'b1;
				cnt_q  <= MUL_CNT_W'(MUL_DIGITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// shift-add one digit a cycle; the low word collects retired bits
	always_ff @(posedge clk) begin
		if (launch) begin
			a_q  <= op_a;
			b_q  <= {1'b0, op_b};
			hi_q <= '0;
			lo_q <= '0;
		end else if (busy_q) begin
			hi_q <= sum[39:8];
			lo_q <= {sum[7:0], lo_q[31:8]};
			b_q  <= b_q >> MUL_DIGIT_W;
		end
	end

	// full product >> 30
	assign prod = {hi_q[28:0], lo_q[31:30]};
	assign done = done_q;

endmodule
